// ===== design/tisle_pkg.sv =====
// Shared types and constants for the telnet IAC strip line editor.
// No dependencies; used by the top level and its checker.
`default_nettype none

package tisle_pkg;

    // Telnet command codes
    localparam logic [7:0] CODE_IAC  = 8'd255;
    localparam logic [7:0] CODE_SE   = 8'd240;
    localparam logic [7:0] CODE_SB   = 8'd250;
    localparam logic [7:0] CODE_WILL = 8'd251;
    localparam logic [7:0] CODE_DONT = 8'd254;

    // Character codes
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_LF    = 8'h0a;
    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DEL   = 8'h7f;

    // Result field widths
    localparam int LEN_W = 6;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // Telnet command parser state
    typedef enum logic [2:0] {
        OPT_NONE    = 3'd0,
        OPT_SEEN    = 3'd1,
        OPT_ARG     = 3'd2,
        OPT_SUB     = 3'd3,
        OPT_SUB_IAC = 3'd4
    } t_opt_state;

    // Control sequencer state
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_ERASE_SP = 3'd1,
        ST_ERASE_BS = 3'd2,
        ST_DUMP     = 3'd3,
        ST_MARK     = 3'd4
    } t_ctl_state;

    // Action decoded from one ordinary byte
    typedef struct packed {
        logic line_end;
        logic erase;
        logic keep;
    } t_rx_action;

endpackage : tisle_pkg

`default_nettype wire

// ===== design/tisle_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tisle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule : tisle_ram

`default_nettype wire

// ===== design/telnet_iac_strip_line_editor_unit.sv =====
// Telnet receive line editor: strips IAC sequences, edits and buffers a line.
// Depends on tisle_pkg and tisle_ram (line store).
//
// Usage:
//   Slave stream (i_s_axis_*) takes one received byte per transfer.
//   Master stream (o_m_axis_*) returns results: tuser is the kind (echo byte,
//   line byte, end marker), tdata carries the byte and the line length, tlast
//   marks the final result caused by one input byte.
//   Config channel (i_cfg_*) writes echo_enable; always ready, write it only
//   while the block is idle.
// Results per byte:
//   For a byte with no result or one result, that result is registered
//   straight into the output register.
//   An erase with echo on gives three echo results.
//   A line end with N buffered characters (N >= 1) is followed by N line
//   bytes read one per cycle from the line store while the output does not
//   stall, then the end marker. An empty line gives the end marker only.
// Reset: parser idle, no pending CR, line empty, echo off. The line store is
//   not cleared; only written positions are ever read.
// Stall: while a result waits in the output register, no new byte is taken
//   and the sequencer holds.
`default_nettype none

module telnet_iac_strip_line_editor_unit #(
    parameter int LINE_CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Config write
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic        i_cfg_data,       // echo_enable
    // Received bytes
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // Results
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [15:0] o_m_axis_tdata,   // [7:0] data_byte, [13:8] line_length, pad
    output      logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output      logic        o_m_axis_tlast    // last
);

    localparam int AW = $clog2(LINE_CAPACITY);

    // Control registers
    tisle_pkg::t_ctl_state r_state, n_state;
    tisle_pkg::t_opt_state r_opt_state, n_opt_state;
    logic                  r_cr_seen, n_cr_seen;
    logic                  r_echo_enable;
    logic [AW-1:0]         r_line_count, n_line_count;
    logic [AW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_out_valid, n_out_valid;

    // Output payload registers
    tisle_pkg::t_kind      r_out_kind, n_out_kind;
    logic [7:0]            r_out_data, n_out_data;
    logic [AW-1:0]         r_out_len, n_out_len;
    logic                  r_out_last, n_out_last;

    logic                  out_free;
    logic                  in_xfer;
    logic [7:0]            rx;
    tisle_pkg::t_rx_action act;
    logic                  ram_wr_en;
    logic [7:0]            ram_rd_data;

    assign rx       = i_s_axis_tdata;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == tisle_pkg::ST_IDLE) && out_free;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {2'b00, tisle_pkg::LEN_W'(r_out_len), r_out_data};

    // Telnet command parser and byte classification
    always_comb begin
        n_opt_state = r_opt_state;
        n_cr_seen   = r_cr_seen;
        act         = '0;
        if (in_xfer) begin
            case (r_opt_state)
                tisle_pkg::OPT_SEEN: begin
                    if (rx inside {[tisle_pkg::CODE_WILL:tisle_pkg::CODE_DONT]}) begin
                        n_opt_state = tisle_pkg::OPT_ARG;
                    end else if (rx == tisle_pkg::CODE_SB) begin
                        n_opt_state = tisle_pkg::OPT_SUB;
                    end else begin
                        n_opt_state = tisle_pkg::OPT_NONE;
                    end
                end
                tisle_pkg::OPT_ARG: begin
                    n_opt_state = tisle_pkg::OPT_NONE;
                end
                tisle_pkg::OPT_SUB: begin
                    if (rx == tisle_pkg::CODE_IAC) begin
                        n_opt_state = tisle_pkg::OPT_SUB_IAC;
                    end
                end
                tisle_pkg::OPT_SUB_IAC: begin
                    n_opt_state = (rx == tisle_pkg::CODE_SE) ? tisle_pkg::OPT_NONE
                                                             : tisle_pkg::OPT_SUB;
                end
                default: begin
                    n_opt_state = tisle_pkg::OPT_NONE;
                    if (rx == tisle_pkg::CODE_IAC) begin
                        n_opt_state = tisle_pkg::OPT_SEEN;
                    end else begin
                        n_cr_seen = 1'b0;
                        // LF or NUL right after CR is part of the same line end
                        if (!(r_cr_seen && (rx inside {tisle_pkg::CHR_LF, tisle_pkg::CHR_NUL}))) begin
                            if (rx inside {tisle_pkg::CHR_CR, tisle_pkg::CHR_LF}) begin
                                act.line_end = 1'b1;
                                n_cr_seen    = (rx == tisle_pkg::CHR_CR);
                            end else if (rx inside {tisle_pkg::CHR_BS, tisle_pkg::CHR_DEL}) begin
                                act.erase = (r_line_count != '0);
                            end else if (rx >= tisle_pkg::CHR_SPACE) begin
                                act.keep = (r_line_count < AW'(LINE_CAPACITY - 1));
                            end
                        end
                    end
                end
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tisle_pkg::ST_IDLE: begin
                if (act.erase && r_echo_enable) begin
                    n_state = tisle_pkg::ST_ERASE_SP;
                end else if (act.line_end && (r_line_count != '0)) begin
                    n_state = tisle_pkg::ST_DUMP;
                end
            end
            tisle_pkg::ST_ERASE_SP: begin
                if (out_free) begin
                    n_state = tisle_pkg::ST_ERASE_BS;
                end
            end
            tisle_pkg::ST_ERASE_BS: begin
                if (out_free) begin
                    n_state = tisle_pkg::ST_IDLE;
                end
            end
            tisle_pkg::ST_DUMP: begin
                if (out_free && (r_rd_idx == r_line_count - AW'(1))) begin
                    n_state = tisle_pkg::ST_MARK;
                end
            end
            tisle_pkg::ST_MARK: begin
                if (out_free) begin
                    n_state = tisle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tisle_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: result register, line count, line store access
    always_comb begin
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_data   = r_out_data;
        n_out_len    = r_out_len;
        n_out_last   = r_out_last;
        n_line_count = r_line_count;
        n_rd_idx     = r_rd_idx;
        ram_wr_en    = 1'b0;
        case (r_state)
            tisle_pkg::ST_IDLE: begin
                if (act.keep) begin
                    ram_wr_en    = 1'b1;
                    n_line_count = r_line_count + AW'(1);
                    if (r_echo_enable) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = tisle_pkg::KIND_ECHO;
                        n_out_data  = rx;
                        n_out_len   = '0;
                        n_out_last  = 1'b1;
                    end
                end else if (act.erase) begin
                    n_line_count = r_line_count - AW'(1);
                    if (r_echo_enable) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = tisle_pkg::KIND_ECHO;
                        n_out_data  = tisle_pkg::CHR_BS;
                        n_out_len   = '0;
                        n_out_last  = 1'b0;
                    end
                end else if (act.line_end) begin
                    n_rd_idx = '0;
                    // Empty line: only the end marker
                    if (r_line_count == '0) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = tisle_pkg::KIND_END;
                        n_out_data  = '0;
                        n_out_len   = '0;
                        n_out_last  = 1'b1;
                    end
                end
            end
            tisle_pkg::ST_ERASE_SP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = tisle_pkg::KIND_ECHO;
                    n_out_data  = tisle_pkg::CHR_SPACE;
                    n_out_len   = '0;
                    n_out_last  = 1'b0;
                end
            end
            tisle_pkg::ST_ERASE_BS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = tisle_pkg::KIND_ECHO;
                    n_out_data  = tisle_pkg::CHR_BS;
                    n_out_len   = '0;
                    n_out_last  = 1'b1;
                end
            end
            tisle_pkg::ST_DUMP: begin
                // Read data always matches r_rd_idx; advance on each transfer
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = tisle_pkg::KIND_LINE;
                    n_out_data  = ram_rd_data;
                    n_out_len   = '0;
                    n_out_last  = 1'b0;
                    n_rd_idx    = r_rd_idx + AW'(1);
                end
            end
            tisle_pkg::ST_MARK: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = tisle_pkg::KIND_END;
                    n_out_data   = '0;
                    n_out_len    = r_line_count;
                    n_out_last   = 1'b1;
                    n_line_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tisle_pkg::ST_IDLE;
            r_opt_state   <= tisle_pkg::OPT_NONE;
            r_cr_seen     <= 1'b0;
            r_echo_enable <= 1'b0;
            r_line_count  <= '0;
            r_rd_idx      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_opt_state  <= n_opt_state;
            r_cr_seen    <= n_cr_seen;
            r_line_count <= n_line_count;
            r_rd_idx     <= n_rd_idx;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_echo_enable <= i_cfg_data;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_len  <= n_out_len;
        r_out_last <= n_out_last;
    end

    // Line store: written at the fill position, read ahead of the dump index
    tisle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_line_count),
        .i_wr_data (rx),
        .i_rd_addr (n_rd_idx),
        .o_rd_data (ram_rd_data)
    );

endmodule : telnet_iac_strip_line_editor_unit

`default_nettype wire

// ===== design/tisle_checker.sv =====
// Port-level checks for the telnet line editor, bound to the top level.
// Depends on tisle_pkg and telnet_iac_strip_line_editor_unit.
`default_nettype none

module tisle_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);

    // End marker closes the results of its byte
    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == tisle_pkg::KIND_END)) |-> o_m_axis_tlast)
        else $error("end marker without tlast");

    // Line bytes never carry tlast; the end marker follows them
    a_line_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == tisle_pkg::KIND_LINE)) |-> !o_m_axis_tlast)
        else $error("line byte flagged last");

    // Length field is zero outside the end marker
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != tisle_pkg::KIND_END))
            |-> (o_m_axis_tdata[15:8] == 8'd0))
        else $error("nonzero length on echo or line byte");

    // No byte taken while a result is stalled
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken during output stall");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
                 && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule : tisle_checker

bind telnet_iac_strip_line_editor_unit tisle_checker u_tisle_checker (.*);

`default_nettype wire

// ===== dv/telnet_iac_strip_line_editor_unit_tb.sv =====
// Self-checking testbench for the telnet IAC strip line editor.
// Needs tisle_pkg and the editor RTL; a directed table runs first, then random telnet traffic.
`default_nettype none

module telnet_iac_strip_line_editor_unit_tb;
    import tisle_pkg::*;

    localparam int LINE_CAP       = 64;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 5;
    localparam int PHASE_BYTES    = 50;
    localparam int DIR_N          = 29;
    localparam int MAX_REPORTS    = 10;

    // One result as it appears on the master stream
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic [5:0]  len;
        logic        last;
    } t_line_result;

    // Directed table row: a received byte or an echo setting
    typedef enum logic {ROW_BYTE = 1'b0, ROW_ECHO = 1'b1} t_row_op;

    typedef struct packed {
        t_row_op     op;
        logic [7:0]  val;
        logic        typed;     // expectation written in the row
        logic        has_res;   // typed row yields one result
        t_kind       kind;
        logic [7:0]  data;
        logic [5:0]  len;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;     // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;     // [7:0] data_byte, [13:8] line_length, pad
    logic [1:0]  o_m_axis_tuser;     // [1:0] kind
    logic        o_m_axis_tlast;

    // Line editor model state
    logic        echo_on;
    t_opt_state  cmd_st;
    logic        cr_pending;
    int          line_len;
    logic [7:0]  line_buf [LINE_CAP];

    t_line_result byte_results[$];
    t_line_result result_expect_q[$];
    logic [7:0]   rx_plan[$];
    t_dir_row     dir_tbl [DIR_N];

    logic calm;
    logic hold_req;
    int   n_err;
    int   n_sent;
    int   n_checked;
    int   n_lines;
    int   n_full_drops;
    int   quiet_cycles;

    telnet_iac_strip_line_editor_unit #(
        .LINE_CAPACITY(LINE_CAP)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_dir_row pred_row(input logic [7:0] b);
        pred_row = '{ROW_BYTE, b, 1'b0, 1'b0, KIND_ECHO, 8'h00, 6'd0};
    endfunction

    function automatic t_dir_row typed_row(input logic [7:0] b, input logic has,
                                           input t_kind k, input logic [7:0] d,
                                           input logic [5:0] l);
        typed_row = '{ROW_BYTE, b, 1'b1, has, k, d, l};
    endfunction

    task automatic add_result(input t_kind k, input logic [7:0] d, input logic [5:0] l);
        t_line_result r;
        r = '{k, d, l, 1'b0};
        byte_results.push_back(r);
    endtask

    // Predict the results of one received byte and advance the editor state
    task automatic edit_rx_byte(input logic [7:0] c);
        logic done;
        int   i;
        byte_results.delete();
        done = 1'b1;
        // telnet command parser
        case (cmd_st)
            OPT_SEEN: begin
                if (c >= CODE_WILL && c <= CODE_DONT) cmd_st = OPT_ARG;
                else if (c == CODE_SB) cmd_st = OPT_SUB;
                else cmd_st = OPT_NONE;
            end
            OPT_ARG: cmd_st = OPT_NONE;
            OPT_SUB: begin
                if (c == CODE_IAC) cmd_st = OPT_SUB_IAC;
            end
            OPT_SUB_IAC: cmd_st = (c == CODE_SE) ? OPT_NONE : OPT_SUB;
            default: begin
                cmd_st = OPT_NONE;
                done   = 1'b0;
            end
        endcase
        if (!done && c == CODE_IAC) begin
            cmd_st = OPT_SEEN;
            done   = 1'b1;
        end
        // LF or NUL right after CR belongs to the same line end
        if (!done && cr_pending) begin
            cr_pending = 1'b0;
            if (c == CHR_LF || c == CHR_NUL) done = 1'b1;
        end
        if (!done) begin
            if (c == CHR_CR || c == CHR_LF) begin
                cr_pending = (c == CHR_CR);
                for (i = 0; i < line_len; i++) add_result(KIND_LINE, line_buf[i], 6'd0);
                add_result(KIND_END, 8'h00, line_len[5:0]);
                line_len = 0;
            end else if (c == CHR_BS || c == CHR_DEL) begin
                if (line_len != 0) begin
                    line_len--;
                    if (echo_on) begin
                        add_result(KIND_ECHO, CHR_BS, 6'd0);
                        add_result(KIND_ECHO, CHR_SPACE, 6'd0);
                        add_result(KIND_ECHO, CHR_BS, 6'd0);
                    end
                end
            end else if (c >= CHR_SPACE) begin
                if (line_len < LINE_CAP - 1) begin
                    line_buf[line_len] = c;
                    line_len++;
                    if (echo_on) add_result(KIND_ECHO, c, 6'd0);
                end else begin
                    n_full_drops++;
                end
            end
        end
    endtask

    task automatic queue_byte_results();
        t_line_result r;
        for (int i = 0; i < byte_results.size(); i++) begin
            r = byte_results[i];
            r.last = (i == byte_results.size() - 1);
            result_expect_q.push_back(r);
        end
    endtask

    // Offer one byte, now and then after a random gap when not calm, and wait for its transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_sent++;
    endtask

    // Echo setting is written only with the block drained
    task automatic write_echo(input logic v);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (result_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        echo_on = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Build a phase of random telnet traffic, mostly well-formed pieces
    task automatic plan_phase(input int n_bytes);
        int w;
        int k;
        int n;
        rx_plan.delete();
        while (rx_plan.size() < n_bytes) begin
            w = $urandom_range(0, 99);
            if (w < 35) begin
                // run of bytes 32 to 254 (mostly printable), now and then long enough to fill the line
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 10);
                for (k = 0; k < n; k++) rx_plan.push_back(8'($urandom_range(32, 254)));
            end else if (w < 45) begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    rx_plan.push_back($urandom_range(0, 1) ? CHR_BS : CHR_DEL);
            end else if (w < 65) begin
                case ($urandom_range(0, 4))
                    0: begin rx_plan.push_back(CHR_CR); rx_plan.push_back(CHR_LF); end
                    1: begin rx_plan.push_back(CHR_CR); rx_plan.push_back(CHR_NUL); end
                    2: rx_plan.push_back(CHR_CR);
                    3: rx_plan.push_back(CHR_LF);
                    default: begin
                        // command between CR and its LF
                        rx_plan.push_back(CHR_CR);
                        rx_plan.push_back(CODE_IAC);
                        rx_plan.push_back(8'($urandom_range(241, 249)));
                        rx_plan.push_back(CHR_LF);
                    end
                endcase
            end else if (w < 80) begin
                rx_plan.push_back(CODE_IAC);
                case ($urandom_range(0, 3))
                    0: rx_plan.push_back(8'($urandom_range(240, 249)));
                    1: begin
                        rx_plan.push_back(8'($urandom_range(251, 254)));
                        rx_plan.push_back(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        rx_plan.push_back(CODE_SB);
                        n = $urandom_range(0, 6);
                        for (k = 0; k < n; k++) begin
                            if ($urandom_range(0, 4) == 0) begin
                                rx_plan.push_back(CODE_IAC);
                                rx_plan.push_back(8'($urandom_range(0, 239)));
                            end else begin
                                rx_plan.push_back(8'($urandom_range(0, 254)));
                            end
                        end
                        rx_plan.push_back(CODE_IAC);
                        rx_plan.push_back(CODE_SE);
                    end
                    default: rx_plan.push_back(CODE_IAC);
                endcase
            end else begin
                rx_plan.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_line_result want,
                                 input t_line_result got);
        n_err++;
        if (n_err <= MAX_REPORTS)
            $display("%0t: %s: exp kind=%0d data=%02h len=%0d last=%0b, %s",
                     $realtime, what, want.kind, want.data, want.len, want.last,
                     $sformatf("got kind=%0d data=%02h len=%0d last=%0b",
                               got.kind, got.data, got.len, got.last));
    endtask

    // Compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_line_result got;
        t_line_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{t_kind'(o_m_axis_tuser), o_m_axis_tdata[7:0], o_m_axis_tdata[13:8],
                    o_m_axis_tlast};
            n_checked++;
            if (o_m_axis_tuser == KIND_END) n_lines++;
            if (result_expect_q.size() == 0) begin
                want = '0;
                note_mismatch("result with nothing pending", want, got);
            end else begin
                want = result_expect_q.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.len !== want.len || got.last !== want.last)
                    note_mismatch("result differs", want, got);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, result_expect_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request, none when calm
    initial begin : result_side
        int  n;
        logic hold_done;
        i_m_axis_tready = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                n = $urandom_range(1, 40);
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin : byte_side
        int r;
        int ph;
        int k;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        calm            = 1'b0;
        hold_req        = 1'b0;
        n_err           = 0;
        n_sent          = 0;
        n_checked       = 0;
        n_lines         = 0;
        n_full_drops    = 0;
        quiet_cycles    = 0;

        // directed table; echo is off after reset
        dir_tbl[0]  = typed_row(CHR_CR, 1'b1, KIND_END, 8'h00, 6'd0);  // empty line
        dir_tbl[1]  = typed_row(CHR_LF, 1'b0, KIND_ECHO, 8'h00, 6'd0);  // CR LF pair
        dir_tbl[2]  = typed_row(CHR_BS, 1'b0, KIND_ECHO, 8'h00, 6'd0);  // erase on empty
        dir_tbl[3]  = typed_row(8'h01, 1'b0, KIND_ECHO, 8'h00, 6'd0);   // control dropped
        dir_tbl[4]  = pred_row(CHR_SPACE);
        dir_tbl[5]  = pred_row(8'hfe);
        dir_tbl[6]  = pred_row(CHR_DEL);
        dir_tbl[7]  = pred_row(8'h41);
        dir_tbl[8]  = pred_row(CODE_IAC);                               // IAC WILL opt
        dir_tbl[9]  = pred_row(CODE_WILL);
        dir_tbl[10] = pred_row(8'h01);
        dir_tbl[11] = pred_row(CODE_IAC);                               // two-byte command
        dir_tbl[12] = pred_row(8'hf4);
        dir_tbl[13] = pred_row(CODE_IAC);                               // subnegotiation
        dir_tbl[14] = pred_row(CODE_SB);
        dir_tbl[15] = pred_row(CHR_NUL);
        dir_tbl[16] = pred_row(CODE_IAC);
        dir_tbl[17] = pred_row(8'h41);
        dir_tbl[18] = pred_row(CODE_IAC);
        dir_tbl[19] = pred_row(CODE_SE);
        dir_tbl[20] = pred_row(CHR_CR);                                 // dumps the line
        dir_tbl[21] = pred_row(CODE_IAC);                               // CR mark survives
        dir_tbl[22] = pred_row(8'hf1);
        dir_tbl[23] = typed_row(CHR_NUL, 1'b0, KIND_ECHO, 8'h00, 6'd0);
        dir_tbl[24] = '{ROW_ECHO, 8'h01, 1'b0, 1'b0, KIND_ECHO, 8'h00, 6'd0};
        dir_tbl[25] = typed_row(8'h7a, 1'b1, KIND_ECHO, 8'h7a, 6'd0);
        dir_tbl[26] = pred_row(CHR_DEL);                                // erase echo
        dir_tbl[27] = typed_row(CHR_LF, 1'b1, KIND_END, 8'h00, 6'd0);  // no echo of line end
        dir_tbl[28] = typed_row(8'h1f, 1'b0, KIND_ECHO, 8'h00, 6'd0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        echo_on    = 1'b0;
        cmd_st     = OPT_NONE;
        cr_pending = 1'b0;
        line_len   = 0;

        for (r = 0; r < DIR_N; r++) begin
            if (dir_tbl[r].op == ROW_ECHO) begin
                write_echo(dir_tbl[r].val[0]);
            end else begin
                send_byte(dir_tbl[r].val);
                edit_rx_byte(dir_tbl[r].val);
                if (!dir_tbl[r].typed)
                    queue_byte_results();
                else if (dir_tbl[r].has_res)
                    result_expect_q.push_back('{dir_tbl[r].kind, dir_tbl[r].data,
                                                dir_tbl[r].len, 1'b1});
            end
        end

        // random phases, echo alternating, the last one without idling
        for (ph = 0; ph < PHASES; ph++) begin
            write_echo(ph % 2 == 0);
            calm = (ph == PHASES - 1);
            plan_phase(PHASE_BYTES);
            if (ph == 0) hold_req = 1'b1;
            for (k = 0; k < rx_plan.size(); k++) begin
                if (ph == 2 && k == rx_plan.size() / 2) begin
                    // sender rests until the block has drained
                    @(negedge i_clk);
                    i_s_axis_tvalid <= 1'b0;
                    while (result_expect_q.size() != 0) @(posedge i_clk);
                end
                send_byte(rx_plan[k]);
                edit_rx_byte(rx_plan[k]);
                queue_byte_results();
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (result_expect_q.size() != 0) @(posedge i_clk);
        repeat (LINE_CAP + SETTLE_CYCLES) @(posedge i_clk);

        $display("covered: %0d bytes in, %0d results checked, %0d line ends, %0d full-line drops",
                 n_sent, n_checked, n_lines, n_full_drops);
        $display("telnet commands, subnegotiation, erase with and without echo; %0d mismatches",
                 n_err);
        if (n_err == 0 && result_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/tisle_pkg.sv
design/tisle_ram.sv
design/telnet_iac_strip_line_editor_unit.sv
design/tisle_checker.sv
dv/telnet_iac_strip_line_editor_unit_tb.sv
